[rtl/fix_message_framer_checker_core_assert.svh]
// Assertion macros for the FIX framer checker core.
// Used by the checker module; expects clk_i and rst_ni in scope.
`ifndef FIX_MESSAGE_FRAMER_CHECKER_CORE_ASSERT_SVH
`define FIX_MESSAGE_FRAMER_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FMFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FMFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fmfc_pkg.sv]
// Shared types and constants for the FIX framer checker core.
// No dependencies.
package fmfc_pkg;

  localparam int MaxLengthDigits = 10;
  localparam int VersionBytes    = 7;
  localparam int PosW            = 4;
  localparam int LenW            = 24;
  localparam int CountW          = 25;
  localparam int VersionW        = 56;
  localparam int RecvSumW        = 10;
  localparam int AddrW           = 2;
  localparam int DataW           = 32;

  localparam logic [LenW-1:0]  MaxBodyReset = 24'd4096;
  localparam logic [AddrW-1:0] AddrMaxBody  = 2'd0;

  localparam logic [7:0] SohByte   = 8'h01;
  localparam logic [7:0] ChrEight  = 8'h38;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrOne    = 8'h31;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrEquals = 8'h3D;

  typedef enum logic [9:0] {
    PhBegin      = 10'b00_0000_0001,
    PhVersion    = 10'b00_0000_0010,
    PhBeginSoh   = 10'b00_0000_0100,
    PhLenTag     = 10'b00_0000_1000,
    PhLenDigits  = 10'b00_0001_0000,
    PhBody       = 10'b00_0010_0000,
    PhSumTag     = 10'b00_0100_0000,
    PhSumDigits  = 10'b00_1000_0000,
    PhSumSoh     = 10'b01_0000_0000,
    PhHunt       = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [3:0] {
    StOk          = 4'd0,
    StBeginTag    = 4'd1,
    StBeginDelim  = 4'd2,
    StLengthTag   = 4'd3,
    StLengthDigit = 4'd4,
    StLengthLimit = 4'd5,
    StSumTag      = 4'd6,
    StSumDigit    = 4'd7,
    StSumDelim    = 4'd8,
    StMismatch    = 4'd9,
    StPartial     = 4'd10
  } status_e;

  typedef struct packed {
    logic                emit;
    status_e             status;
    logic [CountW-1:0]   message_length;
    logic [VersionW-1:0] version_text;
    logic [LenW-1:0]     declared_body_length;
    logic [7:0]          computed_checksum;
  } result_t;

endpackage

[rtl/fmfc_parser.sv]
// Per-byte FIX framing state machine: parse state plus the result of each step.
// Depends on fmfc_pkg.
module fmfc_parser #(
  parameter int MAX_LENGTH_DIGITS = fmfc_pkg::MaxLengthDigits,
  parameter int VERSION_BYTES     = fmfc_pkg::VersionBytes
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_stream_i,
  input  logic [fmfc_pkg::LenW-1:0] max_body_length_i,
  output fmfc_pkg::result_t         result_o
);
  import fmfc_pkg::*;

  localparam int DigW = $clog2(MAX_LENGTH_DIGITS + 1);
  localparam logic [DigW-1:0] DigMax   = DigW'(MAX_LENGTH_DIGITS);
  localparam logic [PosW-1:0] VerCount = PosW'(VERSION_BYTES);

  phase_e              phase_q, phase_d, next_phase;
  logic [PosW-1:0]     pos_q, pos_d, pos_inc;
  logic [LenW-1:0]     len_acc_q, len_acc_d;
  logic [DigW-1:0]     dig_cnt_q, dig_cnt_d;
  logic [LenW-1:0]     body_rem_q, body_rem_d;
  logic [7:0]          run_sum_q, run_sum_d, sum_upd;
  logic [VersionW-1:0] version_q, version_d;
  logic [RecvSumW-1:0] recv_sum_q, recv_sum_d, recv_next;
  logic [CountW-1:0]   byte_cnt_q, byte_cnt_d, cnt_inc;
  logic [LenW+3:0]     len_next;
  logic                is_digit, in_front, emit, do_clear;
  status_e             status;
  logic [CountW-1:0]   res_len;
  logic [7:0]          res_sum;

  assign pos_inc  = pos_q + 1'b1;
  assign cnt_inc  = byte_cnt_q + 1'b1;
  assign is_digit = (data_byte_i >= ChrZero) && (data_byte_i <= 8'h39);
  assign in_front = (phase_q == PhBegin) || (phase_q == PhVersion) ||
                    (phase_q == PhBeginSoh) || (phase_q == PhLenTag) ||
                    (phase_q == PhLenDigits) || (phase_q == PhBody);
  assign sum_upd  = in_front ? run_sum_q + data_byte_i : run_sum_q;

  // times ten as shift-add, then add the digit value
  assign len_next  = {1'b0, len_acc_q, 3'b000} + {3'b000, len_acc_q, 1'b0}
                   + {{(LenW){1'b0}}, data_byte_i[3:0]};
  assign recv_next = {recv_sum_q[RecvSumW-4:0], 3'b000} + {recv_sum_q[RecvSumW-2:0], 1'b0}
                   + {{(RecvSumW-4){1'b0}}, data_byte_i[3:0]};

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    len_acc_d  = len_acc_q;
    dig_cnt_d  = dig_cnt_q;
    body_rem_d = body_rem_q;
    run_sum_d  = run_sum_q;
    version_d  = version_q;
    recv_sum_d = recv_sum_q;
    byte_cnt_d = byte_cnt_q;
    emit       = 1'b0;
    do_clear   = 1'b0;
    status     = StOk;
    next_phase = PhHunt;
    res_len    = cnt_inc;
    res_sum    = sum_upd;

    if (step_i) begin
      if (end_of_stream_i) begin
        emit       = (byte_cnt_q != '0);
        status     = StPartial;
        res_len    = byte_cnt_q;
        res_sum    = run_sum_q;
        do_clear   = 1'b1;
        next_phase = PhBegin;
      end else if (phase_q == PhHunt) begin
        // drop everything but a begin tag start
        if (data_byte_i == ChrEight) begin
          phase_d    = PhBegin;
          pos_d      = PosW'(1);
          len_acc_d  = '0;
          dig_cnt_d  = '0;
          body_rem_d = '0;
          run_sum_d  = data_byte_i;
          version_d  = '0;
          recv_sum_d = '0;
          byte_cnt_d = CountW'(1);
        end
      end else begin
        byte_cnt_d = cnt_inc;
        run_sum_d  = sum_upd;
        unique case (phase_q)
          PhBegin: begin
            if (data_byte_i != ((pos_q == '0) ? ChrEight : ChrEquals)) begin
              emit   = 1'b1;
              status = StBeginTag;
            end else if (pos_inc >= PosW'(2)) begin
              pos_d   = '0;
              phase_d = PhVersion;
            end else begin
              pos_d = pos_inc;
            end
          end
          PhVersion: begin
            version_d = {version_q[VersionW-9:0], data_byte_i};
            if (pos_inc >= VerCount) begin
              pos_d   = '0;
              phase_d = PhBeginSoh;
            end else begin
              pos_d = pos_inc;
            end
          end
          PhBeginSoh: begin
            if (data_byte_i != SohByte) begin
              emit   = 1'b1;
              status = StBeginDelim;
            end else begin
              phase_d = PhLenTag;
            end
          end
          PhLenTag: begin
            if (data_byte_i != ((pos_q == '0) ? ChrNine : ChrEquals)) begin
              emit   = 1'b1;
              status = StLengthTag;
            end else if (pos_inc >= PosW'(2)) begin
              pos_d   = '0;
              phase_d = PhLenDigits;
            end else begin
              pos_d = pos_inc;
            end
          end
          PhLenDigits: begin
            if (data_byte_i == SohByte) begin
              if (dig_cnt_q == '0) begin
                emit   = 1'b1;
                status = StLengthDigit;
              end else begin
                body_rem_d = len_acc_q;
                phase_d    = (len_acc_q == '0) ? PhSumTag : PhBody;
              end
            end else if (!is_digit || dig_cnt_q >= DigMax) begin
              emit   = 1'b1;
              status = StLengthDigit;
            end else if (len_next > {4'b0000, max_body_length_i}) begin
              emit   = 1'b1;
              status = StLengthLimit;
            end else begin
              len_acc_d = len_next[LenW-1:0];
              dig_cnt_d = dig_cnt_q + 1'b1;
            end
          end
          PhBody: begin
            body_rem_d = body_rem_q - 1'b1;
            if (body_rem_q == LenW'(1)) begin
              phase_d = PhSumTag;
            end
          end
          PhSumTag: begin
            if (data_byte_i != ((pos_q == '0) ? ChrOne :
                                (pos_q == PosW'(1)) ? ChrZero : ChrEquals)) begin
              emit   = 1'b1;
              status = StSumTag;
            end else if (pos_inc >= PosW'(3)) begin
              pos_d   = '0;
              phase_d = PhSumDigits;
            end else begin
              pos_d = pos_inc;
            end
          end
          PhSumDigits: begin
            if (!is_digit) begin
              emit   = 1'b1;
              status = StSumDigit;
            end else begin
              recv_sum_d = recv_next;
              if (pos_inc >= PosW'(3)) begin
                pos_d   = '0;
                phase_d = PhSumSoh;
              end else begin
                pos_d = pos_inc;
              end
            end
          end
          PhSumSoh: begin
            emit = 1'b1;
            if (data_byte_i != SohByte) begin
              status = StSumDelim;
            end else if (recv_sum_q != {2'b00, run_sum_q}) begin
              status = StMismatch;
            end else begin
              status     = StOk;
              next_phase = PhBegin;
            end
          end
          default: begin
            do_clear   = 1'b1;
            next_phase = PhBegin;
          end
        endcase
      end

      // every result, and end of stream, starts a fresh message
      if (emit || do_clear) begin
        phase_d    = next_phase;
        pos_d      = '0;
        len_acc_d  = '0;
        dig_cnt_d  = '0;
        body_rem_d = '0;
        run_sum_d  = '0;
        version_d  = '0;
        recv_sum_d = '0;
        byte_cnt_d = '0;
      end
    end
  end

  always_comb begin
    result_o.emit                 = emit;
    result_o.status               = status;
    result_o.message_length       = res_len;
    result_o.version_text         = version_q;
    result_o.declared_body_length = len_acc_q;
    result_o.computed_checksum    = res_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhBegin;
      pos_q      <= '0;
      len_acc_q  <= '0;
      dig_cnt_q  <= '0;
      body_rem_q <= '0;
      run_sum_q  <= '0;
      version_q  <= '0;
      recv_sum_q <= '0;
      byte_cnt_q <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      len_acc_q  <= len_acc_d;
      dig_cnt_q  <= dig_cnt_d;
      body_rem_q <= body_rem_d;
      run_sum_q  <= run_sum_d;
      version_q  <= version_d;
      recv_sum_q <= recv_sum_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

endmodule

[rtl/fix_message_framer_checker_core.sv]
// Top level of the FIX message framer and checksum checker.
// Depends on fmfc_pkg and fmfc_parser.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one stream byte per request,
//   or an end-of-stream marker that reports a partly received message and
//   restarts parsing. Output channel (out_valid_o/out_ready_i) carries one
//   status request at each message end, at the first framing error, or at
//   end of stream; most input bytes produce no output.
//   The APB port holds max_body_length at byte address 0 (reset 4096).
//   Write it only while no request is in flight.
// Pipeline and rate:
//   A byte is captured in the input register, then parsed by the parser
//   state machine, which loads the result register. A status appears once
//   that register is loaded; a stall at the output holds the parser. One byte
//   per cycle is sustained while the receiver does not stall.
// Reset and stall:
//   Reset clears the parse state to wait for a begin tag and empties both
//   register stages. When the receiver stalls with a status waiting, the
//   parser holds; the input register still takes one more byte, then
//   in_ready_o drops until the status is taken.
module fix_message_framer_checker_core #(
  parameter int MAX_LENGTH_DIGITS = fmfc_pkg::MaxLengthDigits,
  parameter int VERSION_BYTES     = fmfc_pkg::VersionBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_stream_i,
  // status stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    status_o,
  output logic [fmfc_pkg::CountW-1:0]   message_length_o,
  output logic [fmfc_pkg::VersionW-1:0] version_text_o,
  output logic [fmfc_pkg::LenW-1:0]     declared_body_length_o,
  output logic [7:0]                    computed_checksum_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmfc_pkg::AddrW-1:0]    paddr,
  input  logic [fmfc_pkg::DataW-1:0]    pwdata,
  output logic [fmfc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import fmfc_pkg::*;

  logic            stage_valid_q;
  logic [7:0]      stage_byte_q;
  logic            stage_eos_q;
  logic            advance, step;
  logic            out_valid_q;
  result_t         step_res, res_q;
  logic [LenW-1:0] max_body_q;

  // The parser may run whenever the result register is free or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = stage_valid_q && advance;
  assign in_ready_o = !stage_valid_q || advance;

  // Input register: take a new request whenever the old one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_byte_q <= data_byte_i;
      stage_eos_q  <= end_of_stream_i;
    end
  end

  fmfc_parser #(
    .MAX_LENGTH_DIGITS (MAX_LENGTH_DIGITS),
    .VERSION_BYTES     (VERSION_BYTES)
  ) u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .data_byte_i       (stage_byte_q),
    .end_of_stream_i   (stage_eos_q),
    .max_body_length_i (max_body_q),
    .result_o          (step_res)
  );

  // Result register: load on a step that emits, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && step_res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && step_res.emit) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign status_o               = res_q.status;
  assign message_length_o       = res_q.message_length;
  assign version_text_o         = res_q.version_text;
  assign declared_body_length_o = res_q.declared_body_length;
  assign computed_checksum_o    = res_q.computed_checksum;

  // Configuration register, written in the APB access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MaxBodyReset;
    end else if (psel && penable && pwrite && pready && (paddr == AddrMaxBody)) begin
      max_body_q <= pwdata[LenW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrMaxBody) ? {{(DataW-LenW){1'b0}}, max_body_q} : '0;

endmodule

[rtl/fmfc_checker.sv]
// Port-level checks for the FIX framer checker core, bound to the top level.
// Depends on fmfc_pkg and fix_message_framer_checker_core_assert.svh.
`include "fix_message_framer_checker_core_assert.svh"

module fmfc_checker #(
  parameter int VERSION_BYTES = fmfc_pkg::VersionBytes
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [3:0]                    status_o,
  input logic [fmfc_pkg::CountW-1:0]   message_length_o,
  input logic [fmfc_pkg::VersionW-1:0] version_text_o,
  input logic [fmfc_pkg::LenW-1:0]     declared_body_length_o,
  input logic [7:0]                    computed_checksum_o
);
  import fmfc_pkg::*;

  // Shortest good message: header, version, SOH, "9=", one digit, SOH, trailer.
  localparam logic [CountW-1:0] MinOkLen    = CountW'(VERSION_BYTES + 14);
  // A length over the limit needs at least one length digit.
  localparam logic [CountW-1:0] MinLimitLen = CountW'(VERSION_BYTES + 6);

  `FMFC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(message_length_o) && $stable(version_text_o) && $stable(declared_body_length_o) && $stable(computed_checksum_o), "status request changed while stalled")
  `FMFC_ASSERT_IMPL(a_status_range, out_valid_o, status_o <= StPartial, "status code out of range")
  `FMFC_ASSERT_IMPL(a_ok_length, out_valid_o && (status_o == StOk), message_length_o >= MinOkLen, "good message shorter than a minimal frame")
  `FMFC_ASSERT_IMPL(a_limit_length, out_valid_o && (status_o == StLengthLimit), message_length_o >= MinLimitLen, "length limit reported before any length digit")

endmodule

bind fix_message_framer_checker_core fmfc_checker #(
  .VERSION_BYTES (VERSION_BYTES)
) u_fmfc_checker (.*);

[dv/tb_top.sv]
// Self-checking bench for the FIX message framer and checksum checker core.
// Depends on fmfc_pkg and fix_message_framer_checker_core; drives byte requests,
// predicts every status request in-line and compares them field by field.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fmfc_pkg::*;

  // One expected status request, at the widths of the result ports.
  typedef struct packed {
    status_e             status;
    logic [CountW-1:0]   message_length;
    logic [VersionW-1:0] version_text;
    logic [LenW-1:0]     declared_body_length;
    logic [7:0]          computed_checksum;
  } frame_report_t;

  // One directed row: a run of stream bytes, optionally closed by a correct
  // trailer and an end-of-stream marker. Typed rows carry their own answer.
  typedef struct {
    string         text;
    bit            add_trailer;
    bit            end_after;
    bit            typed;
    frame_report_t fixed;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i     = 8'h00;
  logic                end_of_stream_i = 1'b0;

  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [3:0]          status_o;
  logic [CountW-1:0]   message_length_o;
  logic [VersionW-1:0] version_text_o;
  logic [LenW-1:0]     declared_body_length_o;
  logic [7:0]          computed_checksum_o;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [AddrW-1:0]    paddr   = '0;
  logic [DataW-1:0]    pwdata  = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // Framer state as the bench sees it, plus the current length limit.
  phase_e              fr_phase;
  int                  fr_pos;
  logic [LenW-1:0]     fr_len;
  int                  fr_digits;
  logic [LenW-1:0]     fr_body_left;
  logic [7:0]          fr_sum;
  logic [VersionW-1:0] fr_version;
  logic [RecvSumW-1:0] fr_trailer;
  logic [CountW-1:0]   fr_count;
  logic [LenW-1:0]     body_limit;

  frame_report_t frame_reports_q[$];
  stim_row_t     stim_rows[$];
  int            error_count = 0;
  int            ready_hold  = 0;
  bit            quiet       = 1'b0;

  fix_message_framer_checker_core u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .data_byte_i            (data_byte_i),
    .end_of_stream_i        (end_of_stream_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .status_o               (status_o),
    .message_length_o       (message_length_o),
    .version_text_o         (version_text_o),
    .declared_body_length_o (declared_body_length_o),
    .computed_checksum_o    (computed_checksum_o),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Framer prediction
  // ---------------------------------------------------------------------------

  // Drop everything learned about the current message.
  function automatic void clear_frame();
    fr_pos       = 0;
    fr_len       = '0;
    fr_digits    = 0;
    fr_body_left = '0;
    fr_sum       = '0;
    fr_version   = '0;
    fr_trailer   = '0;
    fr_count     = '0;
  endfunction

  // Capture the status request for the message so far, then restart.
  function automatic bit close_frame(input status_e st, input phase_e nxt,
                                     output frame_report_t rep);
    rep.status               = st;
    rep.message_length       = fr_count;
    rep.version_text         = fr_version;
    rep.declared_body_length = fr_len;
    rep.computed_checksum    = fr_sum;
    clear_frame();
    fr_phase = nxt;
    return 1'b1;
  endfunction

  // Advance the framer by one request; return 1 when it yields a status.
  function automatic bit advance_framer(input logic [7:0] b, input bit eos,
                                        output frame_report_t rep);
    logic [33:0] grown;
    logic [7:0]  tag_char;
    bit          hit;
    rep = '0;
    hit = 1'b0;
    if (eos) begin
      // End of stream reports a partial message only if bytes were taken.
      if (fr_count != 0) hit = close_frame(StPartial, PhBegin, rep);
      clear_frame();
      fr_phase = PhBegin;
      return hit;
    end
    if (fr_phase == PhHunt) begin
      // While hunting, only an '8' restarts; it counts as the first byte.
      if (b == ChrEight) begin
        clear_frame();
        fr_count = 1;
        fr_sum   = b;
        fr_phase = PhBegin;
        fr_pos   = 1;
      end
      return 1'b0;
    end
    fr_count = fr_count + 1'b1;
    if (fr_phase != PhSumTag && fr_phase != PhSumDigits && fr_phase != PhSumSoh) begin
      fr_sum = fr_sum + b;
    end
    case (fr_phase)
      PhBegin: begin
        tag_char = (fr_pos == 0) ? ChrEight : ChrEquals;
        if (b != tag_char) return close_frame(StBeginTag, PhHunt, rep);
        fr_pos++;
        if (fr_pos >= 2) begin
          fr_pos   = 0;
          fr_phase = PhVersion;
        end
      end
      PhVersion: begin
        fr_version = {fr_version[VersionW-9:0], b};
        fr_pos++;
        if (fr_pos >= VersionBytes) begin
          fr_pos   = 0;
          fr_phase = PhBeginSoh;
        end
      end
      PhBeginSoh: begin
        if (b != SohByte) return close_frame(StBeginDelim, PhHunt, rep);
        fr_phase = PhLenTag;
      end
      PhLenTag: begin
        tag_char = (fr_pos == 0) ? ChrNine : ChrEquals;
        if (b != tag_char) return close_frame(StLengthTag, PhHunt, rep);
        fr_pos++;
        if (fr_pos >= 2) begin
          fr_pos   = 0;
          fr_phase = PhLenDigits;
        end
      end
      PhLenDigits: begin
        if (b == SohByte) begin
          // An empty length field is an error; a zero length skips the body.
          if (fr_digits == 0) return close_frame(StLengthDigit, PhHunt, rep);
          fr_body_left = fr_len;
          fr_phase     = (fr_len == 0) ? PhSumTag : PhBody;
          return 1'b0;
        end
        if (b < ChrZero || b > ChrNine || fr_digits >= MaxLengthDigits) begin
          return close_frame(StLengthDigit, PhHunt, rep);
        end
        grown = 34'(fr_len) * 34'd10 + 34'(b - ChrZero);
        // Report the limit before the offending digit is folded in.
        if (grown > 34'(body_limit)) return close_frame(StLengthLimit, PhHunt, rep);
        fr_len = grown[LenW-1:0];
        fr_digits++;
      end
      PhBody: begin
        fr_body_left = fr_body_left - 1'b1;
        if (fr_body_left == 0) fr_phase = PhSumTag;
      end
      PhSumTag: begin
        tag_char = (fr_pos == 0) ? ChrOne : (fr_pos == 1) ? ChrZero : ChrEquals;
        if (b != tag_char) return close_frame(StSumTag, PhHunt, rep);
        fr_pos++;
        if (fr_pos >= 3) begin
          fr_pos   = 0;
          fr_phase = PhSumDigits;
        end
      end
      PhSumDigits: begin
        if (b < ChrZero || b > ChrNine) return close_frame(StSumDigit, PhHunt, rep);
        fr_trailer = fr_trailer * 10 + (b - ChrZero);
        fr_pos++;
        if (fr_pos >= 3) begin
          fr_pos   = 0;
          fr_phase = PhSumSoh;
        end
      end
      PhSumSoh: begin
        if (b != SohByte) return close_frame(StSumDelim, PhHunt, rep);
        // Trailer values above 255 can never match the 8-bit sum.
        if (fr_trailer != RecvSumW'(fr_sum)) return close_frame(StMismatch, PhHunt, rep);
        return close_frame(StOk, PhBegin, rep);
      end
      default: begin
        clear_frame();
        fr_phase = PhBegin;
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Sum mod 256 of the message bytes, skipping any leading noise.
  function automatic logic [7:0] byte_sum(ref logic [7:0] q[$], input int first);
    logic [7:0] acc;
    acc = '0;
    for (int i = first; i < q.size(); i++) acc = acc + q[i];
    return acc;
  endfunction

  function automatic void append_trailer(ref logic [7:0] q[$], input int val);
    push_text(q, $sformatf("10=%03d", val));
    q.push_back(SohByte);
  endfunction

  function automatic void add_row(input string text, input bit trailer, input bit end_after,
                                  input bit typed, input status_e st, input int len,
                                  input logic [VersionW-1:0] ver, input int decl,
                                  input logic [7:0] sum);
    stim_row_t row;
    row.text                       = text;
    row.add_trailer                = trailer;
    row.end_after                  = end_after;
    row.typed                      = typed;
    row.fixed.status               = st;
    row.fixed.message_length       = CountW'(len);
    row.fixed.version_text         = ver;
    row.fixed.declared_body_length = LenW'(decl);
    row.fixed.computed_checksum    = sum;
    stim_rows.push_back(row);
  endfunction

  // Offer one request, hold it until accepted, then record what it should
  // produce. Insert an idle burst afterwards now and then.
  task automatic send_item(input logic [7:0] b, input bit eos, input bit typed,
                           input frame_report_t fixed);
    frame_report_t rep;
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    if (advance_framer(b, eos, rep)) frame_reports_q.push_back(typed ? fixed : rep);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every status to come back, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_max_body(input logic [LenW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrMaxBody;
    // Upper bits are junk on purpose: only the low 24 bits are kept.
    pwdata  <= {8'($urandom_range(0, 255)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    body_limit = value;
  endtask

  // Build one message with random content; mostly well formed, sometimes
  // preceded by noise, damaged, truncated or given a bad trailer.
  task automatic build_random_frame(ref logic [7:0] frame[$], output bit cut_short);
    int          first;
    int          body_len;
    int unsigned declared;
    int          pad;
    int          pick;
    string       digits;
    frame.delete();
    cut_short = 1'b0;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 5)) frame.push_back(8'($urandom_range(0, 255)));
    end
    first = frame.size();
    push_text(frame, "8=");
    if ($urandom_range(0, 1) == 0) push_text(frame, "FIX.4.4");
    else repeat (VersionBytes) frame.push_back(8'($urandom_range(0, 255)));
    frame.push_back(SohByte);
    push_text(frame, "9=");
    body_len = $urandom_range(0, 12);
    if (body_len > body_limit) body_len = body_limit;
    declared = body_len;
    if ($urandom_range(0, 9) == 0) declared = body_limit + 1 + $urandom_range(0, 999);
    digits = $sformatf("%0d", declared);
    pad = 0;
    if ($urandom_range(0, 3) == 0) pad = $urandom_range(0, MaxLengthDigits - digits.len());
    // Overflow the digit count once in a while.
    if ($urandom_range(0, 19) == 0) pad = MaxLengthDigits - digits.len() + 1;
    repeat (pad) frame.push_back(ChrZero);
    push_text(frame, digits);
    frame.push_back(SohByte);
    repeat (body_len) frame.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 11) == 0) append_trailer(frame, $urandom_range(0, 999));
    else append_trailer(frame, byte_sum(frame, first));
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      frame[$urandom_range(first, frame.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick == 1) begin
      pad = $urandom_range(first + 1, frame.size() - 1);
      while (frame.size() > pad) void'(frame.pop_back());
      cut_short = 1'b1;
    end
  endtask

  task automatic run_random_phase(input int n_bytes);
    logic [7:0] frame[$];
    bit         cut_short;
    int         sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_frame(frame, cut_short);
      foreach (frame[i]) send_item(frame[i], 1'b0, 1'b0, '0);
      if (cut_short || $urandom_range(0, 24) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end
      sent += frame.size();
    end
    // Close the phase so the framer restarts from a known point.
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Status channel: random back-pressure and in-order comparison
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_reports_q.size() == 0) begin
        $display("%0t: unexpected status request, got status %0d len %0d ver %h decl %0d sum %h",
                 $time, status_o, message_length_o, version_text_o,
                 declared_body_length_o, computed_checksum_o);
        error_count++;
      end else begin
        want = frame_reports_q.pop_front();
        if (status_o !== want.status || message_length_o !== want.message_length ||
            version_text_o !== want.version_text ||
            declared_body_length_o !== want.declared_body_length ||
            computed_checksum_o !== want.computed_checksum) begin
          $display("%0t: mismatch, expected status %0d len %0d ver %h decl %0d sum %h",
                   $time, want.status, want.message_length, want.version_text,
                   want.declared_body_length, want.computed_checksum);
          $display("%0t:           got status %0d len %0d ver %h decl %0d sum %h",
                   $time, status_o, message_length_o, version_text_o,
                   declared_body_length_o, computed_checksum_o);
          error_count++;
        end
      end
    end
    // Stall in bursts of random length; keep ready high in the final phase.
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 14) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]      frame[$];
    logic [LenW-1:0] limits[5];

    body_limit = MaxBodyReset;
    clear_frame();
    fr_phase = PhBegin;

    // Directed rows, run with the reset length limit of 4096.
    // A bad first byte right after reset: the extreme value 0xFF.
    add_row("\377", 0, 0, 1, StBeginTag, 1, '0, 0, 8'hFF);
    // Hunting drops non-'8' bytes without a status.
    add_row("\001\377q", 0, 0, 0, StOk, 0, '0, 0, 0);
    // End of stream with nothing received yields nothing.
    add_row("", 0, 1, 0, StOk, 0, '0, 0, 0);
    add_row("8", 0, 1, 1, StPartial, 1, '0, 0, 8'h38);
    // Empty length, too many digits, non-digit in length, length over limit.
    add_row("8=FIX.4.4\0019=\001", 0, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4\0019=00000000000", 0, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4\0019=1a", 0, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4\0019=4097", 0, 0, 0, StOk, 0, '0, 0, 0);
    // Partial message inside the body, at the largest accepted length.
    add_row("8=FIX.4.4\0019=4096\001ab", 0, 1, 0, StOk, 0, '0, 0, 0);
    // Good messages: all-ones version with zero body, then ten length digits.
    add_row("8=\377\377\377\377\377\377\377\0019=0\001", 1, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4\0019=0000000003\001a\001c", 1, 0, 0, StOk, 0, '0, 0, 0);
    // After a good message the next byte must start a message.
    add_row("Z", 0, 0, 0, StOk, 0, '0, 0, 0);
    // Bad length tag; the offending '8' must not restart a message.
    add_row("zz8=FIX.4.4\0018=FIX", 0, 1, 0, StOk, 0, '0, 0, 0);
    // Trailer errors: tag, digit, delimiter, and a value above 255.
    add_row("8=FIX.4.4\0019=0\00111", 0, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4\0019=0\00110=1x", 0, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4\0019=0\00110=999X", 0, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4\0019=0\00110=999\001", 0, 0, 0, StOk, 0, '0, 0, 0);
    // Bad '=' after '8', then a missing SOH after the version.
    add_row("8X", 0, 0, 0, StOk, 0, '0, 0, 0);
    add_row("8=FIX.4.4X", 0, 1, 0, StOk, 0, '0, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[k]) begin
      frame.delete();
      push_text(frame, stim_rows[k].text);
      if (stim_rows[k].add_trailer) append_trailer(frame, byte_sum(frame, 0));
      foreach (frame[i]) send_item(frame[i], 1'b0, stim_rows[k].typed, stim_rows[k].fixed);
      if (stim_rows[k].end_after) begin
        send_item(8'($urandom_range(0, 255)), 1'b1, stim_rows[k].typed, stim_rows[k].fixed);
      end
    end

    // Random phases across length limits, the extremes first; the last
    // phase runs without idling on either side.
    limits = '{LenW'(0), {LenW{1'b1}}, LenW'($urandom_range(1, 40)),
               LenW'($urandom_range(0, 24'hFFFFFF)), MaxBodyReset};
    for (int p = 0; p < 5; p++) begin
      settle();
      write_max_body(limits[p]);
      if (p == 4) quiet = 1'b1;
      run_random_phase(330);
    end
    settle();

    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/fmfc_pkg.sv
rtl/fmfc_parser.sv
rtl/fix_message_framer_checker_core.sv
rtl/fmfc_checker.sv
dv/tb_top.sv
